// ===== design/fct_pkg.sv =====
package fct_pkg;

  localparam int PlaneCount = 6;
  localparam int CoordW     = 32;
  localparam int RadiusW    = 31;
  localparam int PlaneIdxW  = 3;
  localparam int OpW        = 2;
  localparam int Axes       = 3;

  // exact widths of the distance arithmetic
  localparam int DiffW  = CoordW + 1;            // corner minus plane point
  localparam int ProdW  = DiffW + CoordW;        // one term of the dot product
  localparam int DistW  = ProdW + 2;             // sum of three terms
  localparam int SqW    = 2 * CoordW;            // |n|^2, three squares fit unsigned
  localparam int HalfW  = SqW / 2;               // |n|^2 is split for the radius product
  localparam int PartW  = RadiusW + HalfW;       // radius times one half of |n|^2
  localparam int FracW  = 16;                    // Q16.16 fraction bits
  localparam int SphW   = PartW + HalfW + 2;     // scaled sphere distance, signed

  localparam int NumStages = 5;                  // pipeline stages inside one cell

  // stream packing
  localparam int InFieldW = 2 * Axes * CoordW + RadiusW;
  localparam int InDataW  = ((InFieldW + 7) / 8) * 8;
  localparam int InUserW  = OpW + PlaneIdxW;
  localparam int OutDataW = 8;

  typedef enum logic [OpW-1:0] {
    OpWrite  = 2'd0,
    OpBox    = 2'd1,
    OpSphere = 2'd2
  } op_e;

  typedef logic signed [CoordW-1:0] coord_t;
  typedef coord_t [Axes-1:0] vec_t;

  typedef struct packed {
    op_e                  op;
    logic [PlaneIdxW-1:0] plane_index;
    vec_t                 vec_a;
    vec_t                 vec_b;
    logic [RadiusW-1:0]   radius;
    logic                 visible;
  } item_t;

  typedef struct packed {
    logic  valid;
    item_t item;
  } link_t;

endpackage

// ===== design/frustum_culling_test_unit.sv =====
// frustum culling test unit
//
// input stream (s_axis): one word per operation. tuser carries the operation
// (write plane, box test, sphere test) and the plane index; tdata carries the
// two vectors and the sphere radius in Q16.16. unused operation codes are
// taken and dropped.
// output stream (m_axis): one word per box or sphere test, tdata bit 0 is the
// visible flag. plane writes give no output word.
//
// six cells in a row, one per plane, each five pipeline stages deep; every
// word walks through all cells. a test leaves on m_axis from an output
// register after the last cell, and one word is taken per cycle when the
// output keeps up. a plane write lands in its cell as it passes, so later
// tests see it and earlier ones do not.
//
// reset empties the pipeline and the output register; plane contents are not
// cleared, a plane must be written before a test uses it.
// when m_axis stalls, words close up behind the output register and s_axis
// keeps taking words until every stage is full.
module frustum_culling_test_unit import fct_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  // vec_a_x, vec_a_y, vec_a_z, vec_b_x, vec_b_y, vec_b_z, radius, zero pad
  input  logic [InDataW-1:0]  s_axis_tdata,
  // op, plane_index
  input  logic [InUserW-1:0]  s_axis_tuser,
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // visible, zero pad
  output logic [OutDataW-1:0] m_axis_tdata
);

  link_t                 link [PlaneCount+1];
  logic [PlaneCount:0]   rdy;
  logic [OpW-1:0]        op_raw;
  logic                  op_known;
  logic                  last_is_test;
  logic                  take;
  logic                  m_v_q;
  logic                  m_vis_q;

  assign op_raw   = s_axis_tuser[OpW-1:0];
  assign op_known = (op_raw == OpWrite) || (op_raw == OpBox) || (op_raw == OpSphere);

  always_comb begin
    link[0].valid            = s_axis_tvalid && op_known;
    link[0].item.op          = op_e'(op_raw);
    link[0].item.plane_index = s_axis_tuser[InUserW-1:OpW];
    for (int i = 0; i < Axes; i++) begin
      link[0].item.vec_a[i] = s_axis_tdata[i*CoordW +: CoordW];
      link[0].item.vec_b[i] = s_axis_tdata[(Axes+i)*CoordW +: CoordW];
    end
    link[0].item.radius  = s_axis_tdata[2*Axes*CoordW +: RadiusW];
    link[0].item.visible = 1'b1;
  end

  assign s_axis_tready = rdy[0];

  for (genvar k = 0; k < PlaneCount; k++) begin : g_cell
    fct_cell u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .cell_id_i (PlaneIdxW'(k)),
      .in_i      (link[k]),
      .ready_o   (rdy[k]),
      .out_o     (link[k+1]),
      .ready_i   (rdy[k+1])
    );
  end

  // plane writes leave the chain here without an output word
  assign last_is_test = (link[PlaneCount].item.op == OpBox) ||
                        (link[PlaneCount].item.op == OpSphere);
  assign take            = !m_v_q || m_axis_tready;
  assign rdy[PlaneCount] = take || !last_is_test;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_v_q <= 1'b0;
    end else if (take) begin
      m_v_q <= link[PlaneCount].valid && last_is_test;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      m_vis_q <= link[PlaneCount].item.visible;
    end
  end

  assign m_axis_tvalid = m_v_q;
  assign m_axis_tdata  = OutDataW'(m_vis_q);

endmodule

// ===== design/fct_cell.sv =====
module fct_cell import fct_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic [PlaneIdxW-1:0] cell_id_i,
  input  link_t                in_i,
  output logic                 ready_o,
  output link_t                out_o,
  input  logic                 ready_i
);

  // plane held by this cell
  vec_t nrm_q;
  vec_t pt_q;

  logic [NumStages-1:0] v_q;
  logic [NumStages-1:0] en;
  item_t                item_q [NumStages];

  // stage A: differences
  logic signed [DiffW-1:0] dif1_a_q [Axes];
  logic signed [DiffW-1:0] dif2_a_q [Axes];
  vec_t                    nrm_a_q;
  logic signed [DiffW-1:0] dif1_d [Axes];
  logic signed [DiffW-1:0] dif2_d [Axes];

  // stage B: products
  logic signed [ProdW-1:0] p1_b_q [Axes];
  logic signed [ProdW-1:0] p2_b_q [Axes];
  logic        [SqW-1:0]   sq_b_q [Axes];
  logic signed [ProdW-1:0] p1_d [Axes];
  logic signed [ProdW-1:0] p2_d [Axes];
  logic signed [SqW-1:0]   sq_d [Axes];

  // stage C: sums
  logic signed [DistW-1:0] d1_c_q, d2_c_q;
  logic        [SqW-1:0]   s_c_q;
  logic signed [DistW-1:0] d1_c_d, d2_c_d;
  logic        [SqW-1:0]   s_c_d;

  // stage D: radius times |n|^2 in two halves
  logic signed [DistW-1:0] d1_d_q, d2_d_q;
  logic        [PartW-1:0] rlo_d_q, rhi_d_q;
  logic        [PartW-1:0] rlo_d, rhi_d;

  // stage E: decision
  logic signed [SphW-1:0]  sph_d;
  logic                    is_test;
  logic                    reject;
  item_t                   out_item_d;

  logic                    wr_plane;

  // a stage loads when it is empty or its contents move on
  always_comb begin
    en[NumStages-1] = !v_q[NumStages-1] || ready_i;
    for (int j = NumStages - 2; j >= 0; j--) begin
      en[j] = !v_q[j] || en[j+1];
    end
  end

  assign ready_o = en[0];

  assign wr_plane = in_i.valid && en[0] && (in_i.item.op == OpWrite) &&
                    (in_i.item.plane_index == cell_id_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en[0]) begin
        v_q[0] <= in_i.valid;
      end
      for (int j = 1; j < NumStages; j++) begin
        if (en[j]) begin
          v_q[j] <= v_q[j-1];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_plane) begin
      nrm_q <= in_i.item.vec_a;
      pt_q  <= in_i.item.vec_b;
    end
  end

  // corner choice by normal sign; a sphere uses its center
  always_comb begin
    for (int i = 0; i < Axes; i++) begin
      coord_t a, b, n, p, c1, c2;
      a = in_i.item.vec_a[i];
      b = in_i.item.vec_b[i];
      n = nrm_q[i];
      p = pt_q[i];
      if (in_i.item.op == OpBox) begin
        c1 = (!n[CoordW-1] && (n != '0)) ? b : a;
        c2 = n[CoordW-1] ? a : b;
      end else begin
        c1 = a;
        c2 = a;
      end
      dif1_d[i] = $signed({c1[CoordW-1], c1}) - $signed({p[CoordW-1], p});
      dif2_d[i] = $signed({c2[CoordW-1], c2}) - $signed({p[CoordW-1], p});
    end
  end

  always_comb begin
    for (int i = 0; i < Axes; i++) begin
      p1_d[i] = dif1_a_q[i] * $signed(nrm_a_q[i]);
      p2_d[i] = dif2_a_q[i] * $signed(nrm_a_q[i]);
      sq_d[i] = $signed(nrm_a_q[i]) * $signed(nrm_a_q[i]);
    end
  end

  always_comb begin
    d1_c_d = DistW'(p1_b_q[0]) + DistW'(p1_b_q[1]) + DistW'(p1_b_q[2]);
    d2_c_d = DistW'(p2_b_q[0]) + DistW'(p2_b_q[1]) + DistW'(p2_b_q[2]);
    s_c_d  = sq_b_q[0] + sq_b_q[1] + sq_b_q[2];
  end

  always_comb begin
    rlo_d = item_q[2].radius * s_c_q[HalfW-1:0];
    rhi_d = item_q[2].radius * s_c_q[SqW-1:HalfW];
  end

  // sphere: second distance is dot(c - p, n) * 2^16 + r * |n|^2
  always_comb begin
    sph_d = SphW'($signed({d1_d_q, {FracW{1'b0}}})) +
            SphW'($signed({1'b0, rhi_d_q, {HalfW{1'b0}}})) +
            SphW'($signed({1'b0, rlo_d_q}));
    is_test = (item_q[3].op == OpBox) || (item_q[3].op == OpSphere);
    reject  = is_test && d1_d_q[DistW-1] &&
              ((item_q[3].op == OpBox) ? d2_d_q[DistW-1] : sph_d[SphW-1]);
    out_item_d         = item_q[3];
    out_item_d.visible = item_q[3].visible && !reject;
  end

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      item_q[0] <= in_i.item;
      nrm_a_q   <= nrm_q;
      dif1_a_q  <= dif1_d;
      dif2_a_q  <= dif2_d;
    end
    if (en[1]) begin
      item_q[1] <= item_q[0];
      p1_b_q    <= p1_d;
      p2_b_q    <= p2_d;
      for (int i = 0; i < Axes; i++) begin
        sq_b_q[i] <= sq_d[i];
      end
    end
    if (en[2]) begin
      item_q[2] <= item_q[1];
      d1_c_q    <= d1_c_d;
      d2_c_q    <= d2_c_d;
      s_c_q     <= s_c_d;
    end
    if (en[3]) begin
      item_q[3] <= item_q[2];
      d1_d_q    <= d1_c_q;
      d2_d_q    <= d2_c_q;
      rlo_d_q   <= rlo_d;
      rhi_d_q   <= rhi_d;
    end
    if (en[4]) begin
      item_q[4] <= out_item_d;
    end
  end

  assign out_o.valid = v_q[NumStages-1];
  assign out_o.item  = item_q[NumStages-1];

  // a stalled input means every stage holds a word
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !ready_o |-> (&v_q))
    else $error("cell input stalled with an empty stage");

  // a cell may clear visibility but never set it
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (en[NumStages-1] && v_q[NumStages-2]) |=>
      (!item_q[NumStages-1].visible || $past(item_q[NumStages-2].visible)))
    else $error("cell raised visibility");

  // at most one word enters per cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    1'b1 |=> ($countones(v_q) <= $past($countones(v_q)) + 1))
    else $error("cell occupancy grew by more than one");

endmodule
